// ===== hdl/svt_pkg.sv =====
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types, op codes, widths and the sine table of the vertex transform
// unit.
// ----------------------------------------------------------------------------
package svt_pkg;

    // op codes
    localparam logic [2:0] OP_ACC   = 3'd0;
    localparam logic [2:0] OP_FIN   = 3'd1;
    localparam logic [2:0] OP_TRANS = 3'd2;
    localparam logic [2:0] OP_ROT   = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;
    localparam logic [2:0] OP_ALPHA = 3'd5;

    localparam int MAX_GROUP_VERTICES_DEF = 4096;
    localparam int COUNT_FIELD_MAX        = 8191;

    localparam int COORD_W = 29;   // working coordinate
    localparam int TRIG_W  = 18;   // signed sine / cosine, +-65536
    localparam int PROD_W  = COORD_W + TRIG_W;
    localparam int PIV_W   = 18;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 13;
    localparam int DIV_STEPS = SUM_W;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam int QUARTER_STEPS = 64;

    typedef logic [16:0] qtab_t [QUARTER_STEPS+1];

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_PIVOT, ST_TRIG, ST_MULA, ST_MULB, ST_ROT,
        ST_SMULA, ST_SMULB, ST_SDIV, ST_OUT
    } state_t;

    typedef enum logic [1:0] {AX_Z, AX_X, AX_Y} axis_t;

    typedef struct packed {
        logic  load;
        logic  div_step;
        logic  pivot_set;
        logic  trig;
        logic  mul_a;
        logic  mul_b;
        logic  rot;
        logic  smul_a;
        logic  smul_b;
        logic  sdiv;
        logic  out_write;
        axis_t axis;
    } dp_cmd_t;

    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        return pr[123:60];
    endfunction

    // long division, shift and subtract
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q60 Taylor series, evaluated at elaboration only
    function automatic qtab_t build_qtab();
        qtab_t t;
        logic [63:0] x, x2, term, s, den;
        for (int k = 0; k <= QUARTER_STEPS; k++) begin
            x = (PI_Q60 >> 7) * 64'(k);
            x2 = mul_q60(x, x);
            term = x;
            s = x;
            for (int n = 1; n < 30; n++) begin
                if (term != 64'd0) begin
                    den = 64'(2 * n) * 64'(2 * n + 1);
                    term = div_u64(mul_q60(term, x2), den);
                    if (n[0]) begin
                        s = s - term;
                    end else begin
                        s = s + term;
                    end
                end
            end
            t[k] = s[60:44];
        end
        t[0] = 17'd0;
        t[QUARTER_STEPS] = 17'd65536;
        return t;
    endfunction

    localparam qtab_t QUARTER_SINE = build_qtab();

    function automatic logic signed [TRIG_W-1:0] sine_of(logic [7:0] a);
        logic [16:0] v;
        logic signed [TRIG_W-1:0] sv;
        if (a[6]) begin
            v = QUARTER_SINE[7'd64 - {1'b0, a[5:0]}];
        end else begin
            v = QUARTER_SINE[{1'b0, a[5:0]}];
        end
        sv = $signed({1'b0, v});
        return a[7] ? -sv : sv;
    endfunction

endpackage

// ===== hdl/svt_ctrl.sv =====
// ----------------------------------------------------------------------------
// svt_ctrl
// Sequencer: accepts beats, steps the datapath, owns the result valid.
// ----------------------------------------------------------------------------
module svt_ctrl import svt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [2:0] s_op,
    output logic       s_ready,
    input  logic       m_ready,
    output logic       m_valid,
    output dp_cmd_t    cmd
);

    state_t      state_reg, state_next;
    axis_t       axis_reg, axis_next;
    logic [4:0]  step_reg, step_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= AX_Z;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_op)
                        OP_FIN: begin
                            state_next = ST_DIV;
                            step_next  = '0;
                        end
                        OP_TRANS, OP_ALPHA: state_next = ST_OUT;
                        OP_ROT: begin
                            state_next = ST_TRIG;
                            axis_next  = AX_Z;
                        end
                        OP_SCALE: state_next = ST_SMULA;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 5'd1;
                if (step_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ST_PIVOT;
                end
            end
            ST_PIVOT: begin
                cmd.pivot_set = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_TRIG: begin
                cmd.trig   = 1'b1;
                state_next = ST_MULA;
            end
            ST_MULA: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MULB;
            end
            ST_MULB: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                cmd.rot = 1'b1;
                unique case (axis_reg)
                    AX_Z: begin
                        axis_next  = AX_X;
                        state_next = ST_TRIG;
                    end
                    AX_X: begin
                        axis_next  = AX_Y;
                        state_next = ST_TRIG;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_SMULA: begin
                cmd.smul_a = 1'b1;
                state_next = ST_SMULB;
            end
            ST_SMULB: begin
                cmd.smul_b = 1'b1;
                state_next = ST_SDIV;
            end
            ST_SDIV: begin
                cmd.sdiv   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.out_write) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/svt_datapath.sv =====
// ----------------------------------------------------------------------------
// svt_datapath
// Pivot sums and divider lanes, two shared multipliers, result register.
// ----------------------------------------------------------------------------
module svt_datapath import svt_pkg::*; #(
    parameter int MAX_GROUP_VERTICES = MAX_GROUP_VERTICES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    input  logic [2:0]         s_op,
    input  logic signed [15:0] s_vertex_x,
    input  logic signed [15:0] s_vertex_y,
    input  logic signed [15:0] s_vertex_z,
    input  logic signed [15:0] s_delta_x,
    input  logic signed [15:0] s_delta_y,
    input  logic signed [15:0] s_delta_z,
    input  logic [7:0]         s_face_alpha,
    output logic               m_result_kind,
    output logic signed [15:0] m_out_x,
    output logic signed [15:0] m_out_y,
    output logic signed [15:0] m_out_z,
    output logic [7:0]         m_out_alpha
);

    localparam int LIMIT = (MAX_GROUP_VERTICES < COUNT_FIELD_MAX) ?
                           MAX_GROUP_VERTICES : COUNT_FIELD_MAX;

    function automatic logic signed [15:0] sat16(logic signed [COORD_W:0] v);
        logic signed [15:0] r;
        if (v > (COORD_W+1)'(32767)) begin
            r = 16'sd32767;
        end else if (v < -(COORD_W+1)'(32768)) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // persistent state
    logic signed [SUM_W-1:0]   sum_reg   [3];
    logic signed [SUM_W-1:0]   sum_next  [3];
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [PIV_W-1:0]   pivot_reg [3];
    logic signed [PIV_W-1:0]   pivot_next[3];

    // per-beat working registers
    logic signed [COORD_W-1:0] w_reg [3];
    logic signed [COORD_W-1:0] w_next[3];
    logic signed [15:0]        d_reg [3];
    logic                      kind_reg, add_p_reg;
    logic [7:0]                alpha_reg, alpha_next;
    logic [SUM_W-1:0]          dvd_reg [3];
    logic [SUM_W-1:0]          dvd_next[3];
    logic [CNT_W-1:0]          rem_reg [3];
    logic [CNT_W-1:0]          rem_next[3];
    logic                      neg_reg [3];
    logic signed [TRIG_W-1:0]  sin_reg, cos_reg;
    logic signed [PROD_W-1:0]  prod_reg[4];

    // result register
    logic                      kind_out_reg;
    logic signed [15:0]        ox_reg, oy_reg, oz_reg;
    logic [7:0]                oa_reg;

    logic signed [15:0]        v_in[3];
    logic signed [15:0]        d_in[3];
    logic signed [COORD_W-1:0] rot_a, rot_b, mop0_a, mop1_a;
    logic signed [TRIG_W-1:0]  mop0_b, mop1_b;
    logic signed [PROD_W-1:0]  mul0, mul1;
    logic signed [PROD_W:0]    sum_na, sum_nb;
    logic [7:0]                angle;
    logic signed [19:0]        alpha_sum;
    logic [CNT_W:0]            rem_sh;
    logic signed [SUM_W:0]     quo;
    logic signed [PROD_W-1:0]  biased;
    logic signed [COORD_W:0]   fin[3];

    assign v_in[0] = s_vertex_x;
    assign v_in[1] = s_vertex_y;
    assign v_in[2] = s_vertex_z;
    assign d_in[0] = s_delta_x;
    assign d_in[1] = s_delta_y;
    assign d_in[2] = s_delta_z;

    // rotation pair: Z turns (x,y), X turns (z,y), Y turns (x,z)
    always_comb begin
        unique case (cmd.axis)
            AX_Z: begin
                rot_a = w_reg[0];
                rot_b = w_reg[1];
                angle = d_reg[2][7:0];
            end
            AX_X: begin
                rot_a = w_reg[2];
                rot_b = w_reg[1];
                angle = d_reg[0][7:0];
            end
            default: begin
                rot_a = w_reg[0];
                rot_b = w_reg[2];
                angle = d_reg[1][7:0];
            end
        endcase
    end

    // shared multiplier operands
    always_comb begin
        mop0_a = rot_a;
        mop0_b = cos_reg;
        mop1_a = rot_b;
        mop1_b = sin_reg;
        if (cmd.mul_b) begin
            mop0_a = rot_b;
            mop0_b = cos_reg;
            mop1_a = rot_a;
            mop1_b = sin_reg;
        end else if (cmd.smul_a) begin
            mop0_a = w_reg[0];
            mop0_b = TRIG_W'(d_reg[0]);
            mop1_a = w_reg[1];
            mop1_b = TRIG_W'(d_reg[1]);
        end else if (cmd.smul_b) begin
            mop0_a = w_reg[2];
            mop0_b = TRIG_W'(d_reg[2]);
            mop1_a = w_reg[2];
            mop1_b = TRIG_W'(d_reg[2]);
        end
        mul0 = PROD_W'(mop0_a) * PROD_W'(mop0_b);
        mul1 = PROD_W'(mop1_a) * PROD_W'(mop1_b);
    end

    assign sum_na = (PROD_W+1)'(prod_reg[0]) + (PROD_W+1)'(prod_reg[1]);
    assign sum_nb = (PROD_W+1)'(prod_reg[2]) - (PROD_W+1)'(prod_reg[3]);
    assign alpha_sum = $signed({12'd0, s_face_alpha}) + (20'(s_delta_x) <<< 3);

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        pivot_next = pivot_reg;
        w_next     = w_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        alpha_next = alpha_reg;
        rem_sh     = '0;
        quo        = '0;
        biased     = '0;
        for (int i = 0; i < 3; i++) begin
            fin[i] = (COORD_W+1)'(w_reg[i]) +
                     (add_p_reg ? (COORD_W+1)'(pivot_reg[i]) : '0);
        end

        if (cmd.load) begin
            if (s_op == OP_ACC && count_reg < CNT_W'(LIMIT)) begin
                for (int i = 0; i < 3; i++) begin
                    sum_next[i] = sum_reg[i] + SUM_W'(v_in[i]);
                end
                count_next = count_reg + CNT_W'(1);
            end
            for (int i = 0; i < 3; i++) begin
                dvd_next[i] = sum_reg[i][SUM_W-1] ? SUM_W'(-sum_reg[i]) : sum_reg[i];
                rem_next[i] = '0;
                if (s_op == OP_TRANS) begin
                    w_next[i] = COORD_W'(v_in[i]) + COORD_W'(d_in[i]);
                end else begin
                    w_next[i] = COORD_W'(v_in[i]) - COORD_W'(pivot_reg[i]);
                end
            end
            if (alpha_sum < 20'sd0) begin
                alpha_next = 8'd0;
            end else if (alpha_sum > 20'sd255) begin
                alpha_next = 8'd255;
            end else begin
                alpha_next = alpha_sum[7:0];
            end
        end

        // restoring division, one quotient bit per lane per cycle
        if (cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                rem_sh = {rem_reg[i], dvd_reg[i][SUM_W-1]};
                if (rem_sh >= {1'b0, count_reg}) begin
                    rem_next[i] = CNT_W'(rem_sh - {1'b0, count_reg});
                    dvd_next[i] = {dvd_reg[i][SUM_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = rem_sh[CNT_W-1:0];
                    dvd_next[i] = {dvd_reg[i][SUM_W-2:0], 1'b0};
                end
            end
        end

        if (cmd.pivot_set) begin
            for (int i = 0; i < 3; i++) begin
                quo = neg_reg[i] ? -$signed({1'b0, dvd_reg[i]}) : $signed({1'b0, dvd_reg[i]});
                if (count_reg == '0) begin
                    pivot_next[i] = PIV_W'(d_reg[i]);
                end else begin
                    pivot_next[i] = PIV_W'(quo + (SUM_W+1)'(d_reg[i]));
                end
                sum_next[i] = '0;
            end
            count_next = '0;
        end

        if (cmd.rot) begin
            unique case (cmd.axis)
                AX_Z: begin
                    w_next[0] = COORD_W'(sum_na >>> 16);
                    w_next[1] = COORD_W'(sum_nb >>> 16);
                end
                AX_X: begin
                    w_next[2] = COORD_W'(sum_na >>> 16);
                    w_next[1] = COORD_W'(sum_nb >>> 16);
                end
                default: begin
                    w_next[0] = COORD_W'(sum_na >>> 16);
                    w_next[2] = COORD_W'(sum_nb >>> 16);
                end
            endcase
        end

        // divide by 128 toward zero
        if (cmd.sdiv) begin
            for (int i = 0; i < 3; i++) begin
                biased = prod_reg[i] + (prod_reg[i][PROD_W-1] ? PROD_W'(127) : '0);
                w_next[i] = COORD_W'(biased >>> 7);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i]   <= '0;
                pivot_reg[i] <= '0;
            end
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            pivot_reg <= pivot_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg     <= w_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        alpha_reg <= alpha_next;
        if (cmd.load) begin
            d_reg     <= d_in;
            kind_reg  <= (s_op == OP_ALPHA);
            add_p_reg <= (s_op != OP_TRANS);
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= sum_reg[i][SUM_W-1];
            end
        end
        if (cmd.trig) begin
            sin_reg <= sine_of(angle);
            cos_reg <= sine_of(angle + 8'd64);
        end
        if (cmd.mul_a || cmd.smul_a) begin
            prod_reg[0] <= mul0;
            prod_reg[1] <= mul1;
        end
        if (cmd.mul_b || cmd.smul_b) begin
            prod_reg[2] <= mul0;
            prod_reg[3] <= mul1;
        end
        if (cmd.out_write) begin
            kind_out_reg <= kind_reg;
            if (kind_reg) begin
                ox_reg <= '0;
                oy_reg <= '0;
                oz_reg <= '0;
                oa_reg <= alpha_reg;
            end else begin
                ox_reg <= sat16(fin[0]);
                oy_reg <= sat16(fin[1]);
                oz_reg <= sat16(fin[2]);
                oa_reg <= '0;
            end
        end
    end

    assign m_result_kind = kind_out_reg;
    assign m_out_x       = ox_reg;
    assign m_out_y       = oy_reg;
    assign m_out_z       = oz_reg;
    assign m_out_alpha   = oa_reg;

endmodule

// ===== hdl/skeletal_vertex_transform_unit.sv =====
// ----------------------------------------------------------------------------
// skeletal_vertex_transform_unit
// Applies one skeletal transform to each vertex or face-alpha beat.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Translate and alpha go to the result handoff;
// scale makes two multiply passes and a divide; rotate makes three turns of
// trig load, two multiply passes over a pair of shared multipliers and a
// write back, Z then X then Y; pivot finish gets the mean from a restoring
// divider running one quotient bit a cycle for all three axes. The result
// sits in an output register, so the next beat is accepted while the last
// result still waits on m_ready. Pivot accumulate, pivot finish and unused
// op codes give no result beat. Coordinates saturate to 16 bits.
// ----------------------------------------------------------------------------
module skeletal_vertex_transform_unit import svt_pkg::*; #(
    parameter int MAX_GROUP_VERTICES = MAX_GROUP_VERTICES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic signed [15:0] s_vertex_x,
    input  logic signed [15:0] s_vertex_y,
    input  logic signed [15:0] s_vertex_z,
    input  logic signed [15:0] s_delta_x,
    input  logic signed [15:0] s_delta_y,
    input  logic signed [15:0] s_delta_z,
    input  logic [7:0]         s_face_alpha,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic signed [15:0] m_out_x,
    output logic signed [15:0] m_out_y,
    output logic signed [15:0] m_out_z,
    output logic [7:0]         m_out_alpha
);

    dp_cmd_t cmd;

    svt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    svt_datapath #(
        .MAX_GROUP_VERTICES (MAX_GROUP_VERTICES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_op          (s_op),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_vertex_z    (s_vertex_z),
        .s_delta_x     (s_delta_x),
        .s_delta_y     (s_delta_y),
        .s_delta_z     (s_delta_z),
        .s_face_alpha  (s_face_alpha),
        .m_result_kind (m_result_kind),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z),
        .m_out_alpha   (m_out_alpha)
    );

endmodule
